>>> rtl/dip_pkg.sv
// shared types, constants and codes of the drum instruction packer
`default_nettype none
package dip_pkg;

  localparam int DRUM_DEPTH_DEFAULT = 4096;

  localparam int POS_W      = 13;
  localparam int SLOT_W     = 3;
  localparam int LOC_W      = 12;
  localparam int WORD_W     = 40;
  localparam int INSN_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [POS_W-1:0]  DRUM_SIZE_RESET = 13'd4096;
  localparam logic [31:0]       NOOP_FILL       = 32'h0A0A_0A0A;
  localparam logic [SLOT_W-1:0] SLOT_MAX        = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_DRUM_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_NIBBLE = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD_INSN = 3'd0,
    OP_ADD_DATA = 3'd1,
    OP_ALIGN    = 3'd2,
    OP_PATCH    = 3'd3,
    OP_READ     = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    BYTE_JUMP_HI,
    BYTE_JUMP_LO,
    BYTE_INSN_HI,
    BYTE_INSN_LO
  } byte_sel_t;

  typedef enum logic [1:0] {
    K_BYTE,
    K_FOLD,
    K_JUMP,
    K_WORD
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALIGN,
    S_ALIGN_LO,
    S_PLACE,
    S_PAIR_LO,
    S_DATA,
    S_PATCH,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [INSN_W-1:0] insn;
    logic              resolved;
    logic [WORD_W-1:0] data_word;
    logic [LOC_W-1:0]  target_loc;
    logic [1:0]        target_byte;
    logic [INSN_W-1:0] patch_addr;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  placed_loc;
    logic [SLOT_W-1:0] placed_byte;
    logic [WORD_W-1:0] read_data;
    logic              read_used;
    logic              overflow_flag;
    logic              overwrite_flag;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      clear;
    logic      append;
    byte_sel_t byte_sel;
    logic      put_hi;
    logic      next_word;
    logic      data;
    logic      mark;
    logic      bp_write;
    logic      rd_cap;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [SLOT_W-1:0] bp;
    logic              page_end;
    logic              used_vld;
    logic              clear_done;
    logic              out_busy;
    logic              is_byte;
    logic              is_jump;
    logic              fold_ok;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/drum_instruction_packer_top.sv
// top level of the drum instruction packer: controller plus datapath
//
//   channel   signals                          transfer
//   item      item_valid / item_ready / item   valid and ready high at a clock edge
//   result    result_valid / result_ready /    valid and ready high at a clock edge
//             result
//   config    cfg_we / cfg_index / cfg_data    write at every edge with cfg_we high
//
// one item at a time; add instruction and add data word may take longer than read,
// backpatch and plain ops, set by the read-modify-write steps on the single drum
// write port and one wait for the used mark after a word change.
// after reset a clearing pass sweeps every location of the used map with
// item_ready low; configuration writes are taken throughout.
// a waiting result does not block acceptance of the next item; only its
// final result load waits for the result register to drain.
`default_nettype none
module drum_instruction_packer_top #(
  parameter int DRUM_DEPTH = dip_pkg::DRUM_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  dip_pkg::in_item_t              item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output dip_pkg::out_item_t             result,
  input  logic                           cfg_we,
  input  logic [dip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dip_pkg::CFG_DATA_W-1:0] cfg_data
);

  dip_pkg::dp_cmd_t    cmd;
  dip_pkg::dp_status_t status;

  dip_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  dip_datapath #(
    .DRUM_DEPTH (DRUM_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .status       (status)
  );

endmodule
`default_nettype wire

>>> rtl/dip_ctrl.sv
// sequencing state machine of the drum instruction packer
`default_nettype none
module dip_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  dip_pkg::dp_status_t status,
  output dip_pkg::dp_cmd_t    cmd
);

  dip_pkg::state_t state, state_next;
  dip_pkg::kind_t  kind, kind_next;
  dip_pkg::state_t after_align;
  logic            need_align;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dip_pkg::S_CLEAR;
      kind  <= dip_pkg::K_BYTE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    priority if (status.op == dip_pkg::OP_ADD_INSN) begin
      after_align = dip_pkg::S_PLACE;
    end else if (status.op == dip_pkg::OP_ADD_DATA) begin
      after_align = dip_pkg::S_DATA;
    end else begin
      after_align = dip_pkg::S_FINISH;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    item_ready = 1'b0;
    need_align = 1'b0;
    cmd        = '0;
    cmd.byte_sel = dip_pkg::BYTE_INSN_LO;
    unique case (state)
      dip_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) state_next = dip_pkg::S_IDLE;
      end
      dip_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = dip_pkg::S_DECODE;
        end
      end
      dip_pkg::S_DECODE: begin
        unique case (status.op)
          dip_pkg::OP_ADD_INSN: begin
            priority if (status.is_byte) begin
              kind_next  = dip_pkg::K_BYTE;
              need_align = (status.bp >= 3'd2 && status.page_end) || status.bp >= 3'd4;
            end else if (status.fold_ok) begin
              kind_next  = dip_pkg::K_FOLD;
              need_align = 1'b0;
            end else if (status.is_jump) begin
              kind_next  = dip_pkg::K_JUMP;
              need_align = status.bp >= 3'd3;
            end else begin
              kind_next  = dip_pkg::K_WORD;
              need_align = (status.bp >= 3'd1 && status.page_end) || status.bp >= 3'd3;
            end
            state_next = need_align ? dip_pkg::S_ALIGN : dip_pkg::S_PLACE;
          end
          dip_pkg::OP_ADD_DATA, dip_pkg::OP_ALIGN: state_next = dip_pkg::S_ALIGN;
          dip_pkg::OP_PATCH: state_next = dip_pkg::S_PATCH;
          dip_pkg::OP_READ:  state_next = dip_pkg::S_READ;
          default:           state_next = dip_pkg::S_FINISH;
        endcase
      end
      dip_pkg::S_ALIGN: begin
        priority if (status.bp == 3'd0) begin
          state_next = after_align;
        end else if (status.bp <= 3'd2) begin
          // explicit jump to the next word, high byte first
          cmd.append   = 1'b1;
          cmd.byte_sel = dip_pkg::BYTE_JUMP_HI;
          state_next   = dip_pkg::S_ALIGN_LO;
        end else begin
          cmd.next_word = 1'b1;
          state_next    = after_align;
        end
      end
      dip_pkg::S_ALIGN_LO: begin
        cmd.append    = 1'b1;
        cmd.byte_sel  = dip_pkg::BYTE_JUMP_LO;
        cmd.next_word = 1'b1;
        state_next    = after_align;
      end
      dip_pkg::S_PLACE: begin
        // a fresh word needs the used mark of the current location
        if (status.bp != 3'd0 || status.used_vld) begin
          cmd.mark = 1'b1;
          unique case (kind)
            dip_pkg::K_BYTE: begin
              cmd.append   = 1'b1;
              cmd.byte_sel = dip_pkg::BYTE_INSN_LO;
              state_next   = dip_pkg::S_FINISH;
            end
            dip_pkg::K_FOLD: begin
              if (status.bp >= 3'd3) begin
                // jump folded into the implicit-jump byte
                cmd.put_hi    = 1'b1;
                cmd.byte_sel  = dip_pkg::BYTE_INSN_LO;
                cmd.next_word = 1'b1;
                state_next    = dip_pkg::S_FINISH;
              end else begin
                cmd.append   = 1'b1;
                cmd.byte_sel = dip_pkg::BYTE_INSN_HI;
                state_next   = dip_pkg::S_PAIR_LO;
              end
            end
            default: begin
              cmd.append   = 1'b1;
              cmd.byte_sel = dip_pkg::BYTE_INSN_HI;
              state_next   = dip_pkg::S_PAIR_LO;
            end
          endcase
        end
      end
      dip_pkg::S_PAIR_LO: begin
        cmd.append    = 1'b1;
        cmd.byte_sel  = dip_pkg::BYTE_INSN_LO;
        cmd.next_word = (kind == dip_pkg::K_FOLD) || (kind == dip_pkg::K_JUMP);
        state_next    = dip_pkg::S_FINISH;
      end
      dip_pkg::S_DATA: begin
        if (status.used_vld) begin
          cmd.mark   = 1'b1;
          cmd.data   = 1'b1;
          state_next = dip_pkg::S_FINISH;
        end
      end
      dip_pkg::S_PATCH: begin
        cmd.bp_write = 1'b1;
        state_next   = dip_pkg::S_FINISH;
      end
      dip_pkg::S_READ: begin
        cmd.rd_cap = 1'b1;
        state_next = dip_pkg::S_FINISH;
      end
      dip_pkg::S_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = dip_pkg::S_IDLE;
        end
      end
      default: state_next = dip_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/dip_datapath.sv
// drum and used-map memories, position, flags, configuration and result register
`default_nettype none
module dip_datapath #(
  parameter int DRUM_DEPTH = dip_pkg::DRUM_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dip_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dip_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  dip_pkg::in_item_t                item,
  input  dip_pkg::dp_cmd_t                 cmd,
  input  logic                             result_ready,
  output logic                             result_valid,
  output dip_pkg::out_item_t               result,
  output dip_pkg::dp_status_t              status
);

  localparam int AW = $clog2(DRUM_DEPTH);
  localparam logic [dip_pkg::POS_W-1:0] DEPTH_POS = dip_pkg::POS_W'(DRUM_DEPTH);
  localparam logic [AW-1:0]             LAST_IDX  = AW'(DRUM_DEPTH - 1);

  logic [dip_pkg::WORD_W-1:0] drum_mem [DRUM_DEPTH];
  logic                       used_mem [DRUM_DEPTH];

  logic [dip_pkg::POS_W-1:0]  drum_size;
  logic [3:0]                 jump_nibble;
  dip_pkg::in_item_t          item_reg;
  logic [dip_pkg::POS_W-1:0]  wp;
  logic [dip_pkg::SLOT_W-1:0] bp;
  logic                       overflow_seen;
  logic                       overwrite_seen;
  logic [dip_pkg::WORD_W-1:0] cur_word;
  logic [dip_pkg::POS_W-1:0]  mark_loc;
  logic [dip_pkg::SLOT_W-1:0] mark_byte;
  logic [dip_pkg::WORD_W-1:0] rd_reg;
  logic                       ru_reg;
  logic                       used_vld;
  logic [AW-1:0]              clr_addr;
  logic [dip_pkg::WORD_W-1:0] mem_rdata;
  logic                       used_rdata;

  logic                       in_range;
  logic [dip_pkg::POS_W-1:0]  wp_inc;
  logic [15:0]                jump_code;
  logic [7:0]                 byte_v;
  logic [dip_pkg::WORD_W-1:0] base_word;
  logic [dip_pkg::WORD_W-1:0] slot_word;
  logic [dip_pkg::WORD_W-1:0] hi_word;
  logic [dip_pkg::WORD_W-1:0] patch_word;
  logic                       loc_ok;
  logic                       patch_ok;
  logic                       loc_is_wp;
  logic [AW-1:0]              wp_idx;
  logic [AW-1:0]              loc_idx;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [dip_pkg::WORD_W-1:0] mem_wdata;
  logic                       cur_we;
  logic                       used_we;
  logic [AW-1:0]              used_waddr;
  logic                       used_wdata;
  logic [AW-1:0]              used_raddr;
  logic                       begins_word;
  logic                       placed;

  assign wp_idx    = wp[AW-1:0];
  assign loc_idx   = item_reg.target_loc[AW-1:0];
  assign in_range  = (wp < drum_size) && (wp < DEPTH_POS);
  assign wp_inc    = wp + dip_pkg::POS_W'(1);
  assign jump_code = {jump_nibble, wp_inc[11:0]};
  assign loc_ok    = {1'b0, item_reg.target_loc} < DEPTH_POS;
  assign patch_ok  = loc_ok && (item_reg.target_byte <= 2'd2);
  assign loc_is_wp = {1'b0, item_reg.target_loc} == wp;
  assign begins_word = (cmd.append && bp == '0) || cmd.data;

  always_comb begin
    unique case (cmd.byte_sel)
      dip_pkg::BYTE_JUMP_HI: byte_v = jump_code[15:8];
      dip_pkg::BYTE_JUMP_LO: byte_v = jump_code[7:0];
      dip_pkg::BYTE_INSN_HI: byte_v = item_reg.insn[15:8];
      dip_pkg::BYTE_INSN_LO: byte_v = item_reg.insn[7:0];
      default:               byte_v = item_reg.insn[7:0];
    endcase
  end

  // fresh word: no-ops in every slot, implicit jump to the next location on top
  assign base_word = (bp == '0) ? {wp_inc[7:0], dip_pkg::NOOP_FILL} : cur_word;
  assign hi_word   = {byte_v, cur_word[31:0]};

  always_comb begin
    unique case (bp)
      3'd0:    slot_word = {base_word[39:32], byte_v, base_word[23:0]};
      3'd1:    slot_word = {base_word[39:24], byte_v, base_word[15:0]};
      3'd2:    slot_word = {base_word[39:16], byte_v, base_word[7:0]};
      3'd3:    slot_word = {base_word[39:8], byte_v};
      default: slot_word = base_word;
    endcase
  end

  always_comb begin
    unique case (item_reg.target_byte)
      2'd0:    patch_word = {8'd0, item_reg.patch_addr, 16'd0};
      2'd1:    patch_word = {16'd0, item_reg.patch_addr, 8'd0};
      2'd2:    patch_word = {24'd0, item_reg.patch_addr};
      default: patch_word = '0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_idx;
    mem_wdata = slot_word;
    cur_we    = 1'b0;
    priority if (cmd.append && in_range) begin
      mem_we = 1'b1;
      cur_we = 1'b1;
    end else if (cmd.put_hi && in_range) begin
      mem_we    = 1'b1;
      mem_wdata = hi_word;
      cur_we    = 1'b1;
    end else if (cmd.data && in_range) begin
      mem_we    = 1'b1;
      mem_wdata = item_reg.data_word;
    end else if (cmd.bp_write && patch_ok) begin
      mem_we    = 1'b1;
      mem_waddr = loc_idx;
      mem_wdata = mem_rdata | patch_word;
      cur_we    = loc_is_wp;
    end
  end

  always_comb begin
    used_we    = 1'b0;
    used_waddr = wp_idx;
    used_wdata = 1'b1;
    priority if (cmd.clear) begin
      used_we    = 1'b1;
      used_waddr = clr_addr;
      used_wdata = 1'b0;
    end else if (begins_word && in_range) begin
      used_we = 1'b1;
    end
  end

  assign used_raddr = (item_reg.opcode == dip_pkg::OP_READ) ? loc_idx : wp_idx;

  always_ff @(posedge clk) begin
    if (mem_we) drum_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= drum_mem[loc_idx];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_waddr] <= used_wdata;
    used_rdata <= used_mem[used_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drum_size   <= dip_pkg::DRUM_SIZE_RESET;
      jump_nibble <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dip_pkg::CFG_DRUM_SIZE:   drum_size   <= cfg_data;
        dip_pkg::CFG_JUMP_NIBBLE: jump_nibble <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp             <= '0;
      bp             <= '0;
      overflow_seen  <= 1'b0;
      overwrite_seen <= 1'b0;
      used_vld       <= 1'b0;
      clr_addr       <= '0;
      result_valid   <= 1'b0;
    end else begin
      if ((cmd.append || cmd.put_hi || cmd.data) && !in_range) overflow_seen <= 1'b1;
      if (begins_word && in_range && used_rdata) overwrite_seen <= 1'b1;
      if ((cmd.next_word || cmd.data) && in_range) wp <= wp_inc;
      if (cmd.next_word) begin
        bp <= '0;
      end else if (cmd.append && bp != dip_pkg::SLOT_MAX) begin
        bp <= bp + dip_pkg::SLOT_W'(1);
      end
      // read data at the current location is good when nothing moved in the previous cycle
      used_vld <= !(cmd.load || cmd.clear || cmd.append || cmd.next_word || cmd.data);
      if (cmd.clear) clr_addr <= (clr_addr == LAST_IDX) ? '0 : clr_addr + AW'(1);
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign placed = (item_reg.opcode == dip_pkg::OP_ADD_INSN) ||
                  (item_reg.opcode == dip_pkg::OP_ADD_DATA);

  always_ff @(posedge clk) begin
    if (cmd.load) item_reg <= item;
    if (cur_we) cur_word <= mem_wdata;
    if (cmd.mark) begin
      mark_loc  <= wp;
      mark_byte <= (item_reg.opcode == dip_pkg::OP_ADD_DATA) ? '0 : bp;
    end
    if (cmd.load) begin
      rd_reg <= '0;
      ru_reg <= 1'b0;
    end else if (cmd.rd_cap) begin
      rd_reg <= loc_ok ? mem_rdata : '0;
      ru_reg <= loc_ok && used_rdata;
    end
    if (cmd.out_load) begin
      result.placed_loc     <= placed ? mark_loc : wp;
      result.placed_byte    <= placed ? mark_byte : bp;
      result.read_data      <= rd_reg;
      result.read_used      <= ru_reg;
      result.overflow_flag  <= overflow_seen;
      result.overwrite_flag <= overwrite_seen;
    end
  end

  always_comb begin
    status.op         = item_reg.opcode;
    status.bp         = bp;
    status.page_end   = wp[7:0] == 8'hFF;
    status.used_vld   = used_vld;
    status.clear_done = clr_addr == LAST_IDX;
    status.out_busy   = result_valid && !result_ready;
    status.is_byte    = item_reg.insn[15:8] == 8'd0;
    status.is_jump    = item_reg.insn[15:12] == jump_nibble;
    status.fold_ok    = status.is_jump && item_reg.resolved &&
                        (item_reg.insn[11:8] == wp[11:8]);
  end

endmodule
`default_nettype wire

>>> dv/tb_drum_instruction_packer_top.sv
// testbench for the drum instruction packer: directed and random transactions with a scoreboard
`default_nettype none
module tb_drum_instruction_packer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dip_pkg::*;

  localparam int DEPTH = DRUM_DEPTH_DEFAULT;
  localparam int RUN_LIMIT = 1_000_000;
  localparam logic [2:0] OP_LAST_CODE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  drum_instruction_packer_top u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // packer state as predicted
  logic [WORD_W-1:0] drum_mem [DEPTH];
  bit used_mark [DEPTH];
  bit known_word [DEPTH];
  int known_locs [$];
  int unsigned cur_word = 0;
  int unsigned cur_slot = 0;
  int unsigned size_reg = 4096;
  bit [3:0] jump_nibble = 4'h0;
  bit sticky_ovf = 1'b0;
  bit sticky_ovw = 1'b0;

  in_item_t queued_commands [$];
  out_item_t expected_reports [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  function automatic int unsigned usable_words();
    return (size_reg > DEPTH) ? DEPTH : size_reg;
  endfunction

  function automatic void note_known(int unsigned loc);
    if (!known_word[loc]) begin
      known_word[loc] = 1'b1;
      known_locs.push_back(loc);
    end
  endfunction

  function automatic void open_word();
    if (cur_word < usable_words() && cur_slot == 0) begin
      if (used_mark[cur_word]) sticky_ovw = 1'b1;
      drum_mem[cur_word] = {8'(cur_word + 1), NOOP_FILL};
      used_mark[cur_word] = 1'b1;
      note_known(cur_word);
    end else if (cur_word >= usable_words()) begin
      sticky_ovf = 1'b1;
    end
  endfunction

  // slot -1 is the implicit jump byte
  function automatic void set_slot(int slot, logic [7:0] v);
    if (cur_word >= usable_words()) begin
      sticky_ovf = 1'b1;
      return;
    end
    if (slot < 0) drum_mem[cur_word][39:32] = v;
    else if (slot <= 3) drum_mem[cur_word][(3 - slot) * 8 +: 8] = v;
  endfunction

  function automatic void put_insn_byte(logic [7:0] v);
    open_word();
    set_slot(cur_slot, v);
    if (cur_slot < 7) cur_slot++;
  endfunction

  function automatic void put_insn_pair(logic [15:0] code);
    put_insn_byte(code[15:8]);
    put_insn_byte(code[7:0]);
  endfunction

  function automatic void step_word();
    if (cur_word < usable_words()) cur_word++;
    cur_slot = 0;
  endfunction

  function automatic void close_word();
    if (cur_slot == 0) return;
    if (cur_slot <= 2) put_insn_pair({jump_nibble, 12'(cur_word + 1)});
    step_word();
  endfunction

  function automatic out_item_t predict_packing(in_item_t it);
    out_item_t r;
    logic [15:0] code;
    bit is_jump;
    bit placed;
    int unsigned at_word;
    int unsigned at_slot;
    r = '0;
    placed = 1'b0;
    code = it.insn;
    is_jump = (code[15:12] == jump_nibble);
    at_word = 0;
    at_slot = 0;
    case (it.opcode)
      OP_ADD_INSN: begin
        placed = 1'b1;
        if (code < 16'h0100) begin
          if (cur_slot >= 2 && cur_word[7:0] == 8'hFF) close_word();
          if (cur_slot >= 4) close_word();
          at_word = cur_word;
          at_slot = cur_slot;
          put_insn_byte(code[7:0]);
        end else if (is_jump && it.resolved && code[11:8] == cur_word[11:8]) begin
          // same-page jump folds into the implicit jump byte when fewer than two slots are left
          at_word = cur_word;
          at_slot = cur_slot;
          if (cur_slot >= 3) set_slot(-1, code[7:0]);
          else put_insn_pair(code);
          step_word();
        end else if (is_jump) begin
          if (cur_slot >= 3) close_word();
          at_word = cur_word;
          at_slot = cur_slot;
          put_insn_pair(code);
          step_word();
        end else begin
          if (cur_slot >= 1 && cur_word[7:0] == 8'hFF) close_word();
          if (cur_slot >= 3) close_word();
          at_word = cur_word;
          at_slot = cur_slot;
          put_insn_pair(code);
        end
      end
      OP_ADD_DATA: begin
        close_word();
        placed = 1'b1;
        at_word = cur_word;
        at_slot = 0;
        if (cur_word < usable_words()) begin
          if (used_mark[cur_word]) sticky_ovw = 1'b1;
          drum_mem[cur_word] = it.data_word;
          used_mark[cur_word] = 1'b1;
          note_known(cur_word);
          cur_word++;
        end else begin
          sticky_ovf = 1'b1;
        end
      end
      OP_ALIGN: close_word();
      OP_PATCH: begin
        if (it.target_byte <= 2)
          drum_mem[it.target_loc] = drum_mem[it.target_loc] |
            (WORD_W'(it.patch_addr) << ((2 - it.target_byte) * 8));
      end
      OP_READ: begin
        r.read_data = drum_mem[it.target_loc];
        r.read_used = used_mark[it.target_loc];
      end
      default: ;
    endcase
    if (!placed) begin
      at_word = cur_word;
      at_slot = cur_slot;
    end
    r.placed_loc = POS_W'(at_word);
    r.placed_byte = SLOT_W'(at_slot);
    r.overflow_flag = sticky_ovf;
    r.overwrite_flag = sticky_ovw;
    return r;
  endfunction

  function automatic int pick_gap();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t mk(logic [2:0] op, logic [15:0] insn, logic res,
                                  logic [WORD_W-1:0] data, logic [LOC_W-1:0] loc,
                                  logic [1:0] tb, logic [15:0] addr);
    in_item_t it;
    it.opcode = op;
    it.insn = insn;
    it.resolved = res;
    it.data_word = data;
    it.target_loc = loc;
    it.target_byte = tb;
    it.patch_addr = addr;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int pick;
    it.opcode = OP_ADD_INSN;
    it.insn = 16'($urandom);
    it.resolved = 1'($urandom);
    it.data_word = WORD_W'({$urandom, $urandom});
    it.target_loc = LOC_W'($urandom);
    it.target_byte = 2'($urandom);
    it.patch_addr = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        it.insn = 16'($urandom_range(0, 255));
      end else if (pick < 60) begin
        if (it.insn < 16'h0100) it.insn[8] = 1'b1;
      end else if (pick < 85) begin
        // jump aimed at the current page so that it can fold
        it.insn = {jump_nibble, 4'(cur_word >> 8), 8'($urandom)};
        it.resolved = 1'b1;
      end else begin
        it.insn[15:12] = jump_nibble;
      end
    end else if (pick < 65) begin
      it.opcode = OP_ADD_DATA;
    end else if (pick < 75) begin
      it.opcode = OP_ALIGN;
    end else if (pick < 95 && known_locs.size() > 0) begin
      // only words already written are patched or read back
      it.opcode = (pick < 85) ? OP_PATCH : OP_READ;
      it.target_loc = LOC_W'(known_locs[$urandom_range(0, known_locs.size() - 1)]);
    end else if (pick < 95) begin
      it.opcode = OP_ALIGN;
    end else begin
      it.opcode = 3'($urandom_range(OP_READ + 1, OP_LAST_CODE));
    end
    return it;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    if (idx == CFG_DRUM_SIZE) size_reg = value[12:0];
    else jump_nibble = value[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (queued_commands.size() != 0 || item_valid || expected_reports.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      while (queued_commands.size() >= 2) @(posedge clk);
      queued_commands.push_back(rand_item());
    end
  endtask

  // driver
  always @(posedge clk) begin
    bit accepted;
    accepted = item_valid && item_ready;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (accepted) expected_reports.push_back(predict_packing(item));
      if (item_valid && !accepted) begin
        // hold the transaction until taken
      end else if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (queued_commands.size() > 0) begin
        item <= queued_commands.pop_front();
        item_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected result", 64'(result), 64'd0);
        end else begin
          want = expected_reports.pop_front();
          if (result.placed_loc !== want.placed_loc)
            flag_mismatch("placed_loc", 64'(result.placed_loc), 64'(want.placed_loc));
          if (result.placed_byte !== want.placed_byte)
            flag_mismatch("placed_byte", 64'(result.placed_byte), 64'(want.placed_byte));
          if (result.read_data !== want.read_data)
            flag_mismatch("read_data", 64'(result.read_data), 64'(want.read_data));
          if (result.read_used !== want.read_used)
            flag_mismatch("read_used", 64'(result.read_used), 64'(want.read_used));
          if (result.overflow_flag !== want.overflow_flag)
            flag_mismatch("overflow_flag", 64'(result.overflow_flag),
                          64'(want.overflow_flag));
          if (result.overwrite_flag !== want.overwrite_flag)
            flag_mismatch("overwrite_flag", 64'(result.overwrite_flag),
                          64'(want.overwrite_flag));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    cfg_write(CFG_DRUM_SIZE, 4096);
    cfg_write(CFG_JUMP_NIBBLE, 4'hB);

    // directed: byte and pair packing, folding, alignment, data, patch, read
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h00FF, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h0042, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'hB0FE, 1'b1, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h0100, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'hB005, 1'b1, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h0001, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ALIGN, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'hFFFF, 1'b1, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'hB300, 1'b1, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'hB000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h1234, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h00AA, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ALIGN, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ALIGN, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_DATA, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_ADD_DATA, 16'h0000, 1'b0, '1, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_PATCH, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'hFFFF));
    queued_commands.push_back(mk(OP_PATCH, 16'h0000, 1'b0, '0, 12'd1, 2'd1, 16'h00FF));
    queued_commands.push_back(mk(OP_PATCH, 16'h0000, 1'b0, '0, 12'd1, 2'd2, 16'hFFFF));
    queued_commands.push_back(mk(OP_PATCH, 16'h0000, 1'b0, '0, 12'd0, 2'd3, 16'hFFFF));
    queued_commands.push_back(mk(OP_READ, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_READ, 16'h0000, 1'b0, '0, 12'd1, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_READ + 1, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    queued_commands.push_back(mk(OP_LAST_CODE, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    wait_drained();

    // size above the physical depth, jump nibble zero
    cfg_write(CFG_DRUM_SIZE, 8191);
    cfg_write(CFG_JUMP_NIBBLE, 4'h0);
    run_random(600);
    // leave a word half filled so that it gets restarted later
    queued_commands.push_back(mk(OP_ADD_INSN, 16'h0033, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    wait_drained();

    // shrink below the current position: everything overflows
    cfg_write(CFG_DRUM_SIZE, 1);
    run_random(15);
    wait_drained();
    cfg_write(CFG_DRUM_SIZE, 0);
    run_random(15);
    queued_commands.push_back(mk(OP_ALIGN, 16'h0000, 1'b0, '0, 12'd0, 2'd0, 16'h0));
    wait_drained();

    // grow again: the next word start hits a used word
    cfg_write(CFG_DRUM_SIZE, 4096);
    cfg_write(CFG_JUMP_NIBBLE, 4'hF);
    no_idle = 1'b1;
    run_random(500);
    wait_drained();
    no_idle = 1'b0;

    // size just ahead of the position so that it saturates
    cfg_write(CFG_DRUM_SIZE, cur_word + 20);
    cfg_write(CFG_JUMP_NIBBLE, 4'h7);
    run_random(400);
    wait_drained();

    cfg_write(CFG_DRUM_SIZE, 8191);
    cfg_write(CFG_JUMP_NIBBLE, 4'h5);
    run_random(220);
    wait_drained();
    run_random(220);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
rtl/dip_pkg.sv
rtl/dip_ctrl.sv
rtl/dip_datapath.sv
rtl/drum_instruction_packer_top.sv
dv/tb_drum_instruction_packer_top.sv
